@@ sv/ige_pkg.sv @@
package ige_pkg;

	localparam int DEF_NUM_CLASSES = 16;
	localparam int DEF_NUM_VALUES  = 16;
	localparam int DEF_MAX_SAMPLES = 4096;

	localparam int LABEL_W   = 4;
	localparam int VALUE_W   = 4;
	localparam int OUT_W     = 19;
	localparam int TOTAL_W   = 13;
	localparam int FRAC_BITS = 40;

	localparam logic [OUT_W-1:0] OUT_MAX = '1;

	typedef struct packed {
		logic [LABEL_W-1:0] label;
		logic [VALUE_W-1:0] attr_value;
		logic               last;
	} item_t;

	typedef struct packed {
		logic [OUT_W-1:0]   label_entropy;
		logic [OUT_W-1:0]   info_gain;
		logic [TOTAL_W-1:0] sample_total;
		logic               overflow;
	} result_t;

endpackage

@@ sv/ige_clog.sv @@
module ige_clog #(
	parameter int CNT_W = 13,
	parameter int LW    = CNT_W + $clog2(CNT_W) + 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [CNT_W-1:0] c,
	output logic             done,
	output logic [LW-1:0]    l
);
	import ige_pkg::*;

	localparam int KW  = $clog2(CNT_W);
	localparam int LQW = KW + FRAC_BITS;
	localparam int ITW = $clog2(FRAC_BITS);
	localparam logic [127:0] HALF = 128'h1 << 23;

	typedef enum logic [1:0] {L_IDLE, L_SQ, L_FIN} lstate_t;

	lstate_t              state_q;
	logic [CNT_W-1:0]     c_q;
	logic [KW-1:0]        k_q;
	logic [63:0]          m_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic [ITW-1:0]       it_q;
	logic [2:0]           ph_q;
	logic [63:0]          prod_q;
	logic [127:0]         acc_q;
	logic [LW-1:0]        l_q;
	logic                 done_q;

	logic [KW-1:0]  k_c;
	logic [63:0]    m_c;
	logic [31:0]    mul_a, mul_b;
	logic [63:0]    prod_c;
	logic [LQW-1:0] logq;
	logic [127:0]   rnd;

	assign logq = {k_q, frac_q};
	assign rnd  = acc_q + HALF;

	// position of the leading one
	always_comb begin
		k_c = '0;
		for (int i = 1; i < CNT_W; i++) begin
			if (c[i]) k_c = KW'(i);
		end
	end

	assign m_c = 64'(c) << (6'd63 - 6'(k_c));

	// one shared 32x32 multiplier: square partials, then count times log
	always_comb begin
		mul_a = m_q[31:0];
		mul_b = m_q[31:0];
		if (state_q == L_SQ) begin
			case (ph_q)
				3'd1: mul_b = m_q[63:32];
				3'd2: begin
					mul_a = m_q[63:32];
					mul_b = m_q[63:32];
				end
				default: ;
			endcase
		end else begin
			mul_a = 32'(c_q);
			mul_b = (ph_q == 3'd1) ? 32'(logq[LQW-1:32]) : logq[31:0];
		end
	end

	assign prod_c = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				L_IDLE: begin
					if (start) begin
						c_q    <= c;
						k_q    <= k_c;
						m_q    <= m_c;
						frac_q <= '0;
						it_q   <= '0;
						ph_q   <= '0;
						if (c < CNT_W'(2)) begin
							l_q    <= '0;
							done_q <= 1'b1;
						end else begin
							state_q <= L_SQ;
						end
					end
				end
				L_SQ: begin
					case (ph_q)
						3'd0: begin
							prod_q <= prod_c;
							acc_q  <= '0;
						end
						3'd1: begin
							acc_q  <= 128'(prod_q);
							prod_q <= prod_c;
						end
						3'd2: begin
							acc_q  <= acc_q + (128'(prod_q) << 33);
							prod_q <= prod_c;
						end
						3'd3: acc_q <= acc_q + (128'(prod_q) << 64);
						default: begin
							// keep top 64 bits, renormalise when square is two or more
							if (acc_q[127]) begin
								m_q    <= acc_q[127:64];
								frac_q <= {frac_q[FRAC_BITS-2:0], 1'b1};
							end else begin
								m_q    <= acc_q[126:63];
								frac_q <= {frac_q[FRAC_BITS-2:0], 1'b0};
							end
							it_q <= it_q + 1'b1;
							if (it_q == ITW'(FRAC_BITS - 1)) state_q <= L_FIN;
						end
					endcase
					ph_q <= (ph_q == 3'd4) ? 3'd0 : ph_q + 3'd1;
				end
				L_FIN: begin
					case (ph_q)
						3'd0: prod_q <= prod_c;
						3'd1: begin
							acc_q  <= 128'(prod_q);
							prod_q <= prod_c;
						end
						3'd2: acc_q <= acc_q + (128'(prod_q) << 32);
						default: begin
							l_q     <= LW'(rnd >> 24);
							done_q  <= 1'b1;
							state_q <= L_IDLE;
						end
					endcase
					ph_q <= ph_q + 3'd1;
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign l    = l_q;

endmodule

@@ sv/ige_div.sv @@
module ige_div #(
	parameter int NUM_W = 40,
	parameter int DEN_W = 13
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [NUM_W-1:0]        num,
	input  logic [DEN_W-1:0]        den,
	output logic                    done,
	output logic [ige_pkg::OUT_W-1:0] quo
);
	import ige_pkg::*;

	localparam int CW = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [OUT_W-1:0] res_q;

	logic [DEN_W:0] rem_sh;
	logic           fits;

	assign rem_sh = {rem_q, num_q[NUM_W-1]};
	assign fits   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (start) begin
					busy_q <= 1'b1;
					cnt_q  <= CW'(NUM_W);
					num_q  <= num;
					den_q  <= den;
					rem_q  <= '0;
					quo_q  <= '0;
				end
			end else if (cnt_q != '0) begin
				// one quotient bit per cycle
				rem_q <= fits ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_q << 1 | DEN_W'(num_q[NUM_W-1]);
				num_q <= num_q << 1;
				quo_q <= {quo_q[NUM_W-2:0], fits};
				cnt_q <= cnt_q - 1'b1;
			end else begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
				if (den_q == '0) res_q <= '0;
				else if (quo_q > NUM_W'(OUT_MAX)) res_q <= OUT_MAX;
				else res_q <= quo_q[OUT_W-1:0];
			end
		end
	end

	assign done = done_q;
	assign quo  = res_q;

endmodule

@@ sv/information_gain_engine_core.sv @@
// Information gain engine: counts samples (label, attribute value) and, on the
// item marked last, returns label entropy and attribute information gain, Q.16.
// Input: an item is taken at a clock edge where start is high and busy low.
// A counted item does a read-modify-write of the class, value and pair
// counters in one synchronous memory (S_UCLS, S_UVAL, S_UPAIR); the next item
// may be taken in S_UPAIR. Items past MAX_SAMPLES, or with label/value out of
// range, are dropped and set the overflow flag of the set; a dropped item
// that is not last leaves the block idle. Closing a set first takes
// c*log2(c) of the sample count, then walks all NUM_CLASSES + NUM_VALUES +
// NUM_VALUES*NUM_CLASSES counters through the shared iterative unit, reading
// and clearing each entry, then runs two serial divisions. The result is
// registered on result, with done high for exactly one cycle; it cannot be
// held off, so a receiver must take it then. busy stays high from the closing
// item to done. After reset the block sweeps the counter memory to zero, one
// entry a cycle (all 288 entries at default sizes) with busy high.
module information_gain_engine_core #(
	parameter int NUM_CLASSES = ige_pkg::DEF_NUM_CLASSES,
	parameter int NUM_VALUES  = ige_pkg::DEF_NUM_VALUES,
	parameter int MAX_SAMPLES = ige_pkg::DEF_MAX_SAMPLES
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  ige_pkg::item_t   item,
	output logic             busy,
	output logic             done,
	output ige_pkg::result_t result
);
	import ige_pkg::*;

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int KW    = $clog2(CNT_W);
	localparam int LW    = CNT_W + KW + 16;
	localparam int D     = NUM_CLASSES + NUM_VALUES + NUM_VALUES * NUM_CLASSES;
	localparam int AW    = $clog2(D);
	localparam int SW    = LW + AW + 2;
	localparam int NUM_W = SW - 1;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_UCLS, S_UVAL, S_UPAIR, S_LNGO, S_LNW,
		S_WRD, S_WDAT, S_WLOG, S_DEGO, S_DEW, S_DGGO, S_DGW
	} state_t;

	state_t               state_q;
	logic [LABEL_W-1:0]   lab_q;
	logic [VALUE_W-1:0]   val_q;
	logic                 last_q;
	logic [CNT_W-1:0]     n_q;
	logic                 drop_q;
	logic [AW-1:0]        walk_q;
	logic signed [SW-1:0] acc_e_q, acc_g_q;
	logic [OUT_W-1:0]     ent_q;
	logic                 done_q;
	result_t              result_q;

	logic [CNT_W-1:0] mem_q [D];
	logic [CNT_W-1:0] rdata_q;

	logic             accept, ok;
	logic             mem_re, mem_we;
	logic [AW-1:0]    raddr, waddr;
	logic [CNT_W-1:0] wdata;
	logic             log_start, log_done;
	logic [CNT_W-1:0] log_c;
	logic [LW-1:0]    log_l;
	logic signed [SW-1:0] log_ext;
	logic             div_start, div_done;
	logic [NUM_W-1:0] div_num;
	logic [OUT_W-1:0] div_quo;

	function automatic logic [AW-1:0] val_addr(input logic [VALUE_W-1:0] v);
		return AW'(NUM_CLASSES) + AW'(v);
	endfunction

	function automatic logic [AW-1:0] pair_addr(input logic [VALUE_W-1:0] v,
			input logic [LABEL_W-1:0] y);
		return AW'(NUM_CLASSES + NUM_VALUES) + AW'(v) * AW'(NUM_CLASSES) + AW'(y);
	endfunction

	assign busy   = !(state_q == S_IDLE || (state_q == S_UPAIR && !last_q));
	assign accept = start && !busy;
	assign ok     = (int'(item.label) < NUM_CLASSES) && (int'(item.attr_value) < NUM_VALUES)
			&& (n_q < CNT_W'(MAX_SAMPLES));

	// Within one item the three counters sit in separate regions, and a new
	// item's class read only meets the previous item's pair write, so no
	// read ever sees a write still in flight.
	always_comb begin
		mem_re = 1'b0;
		raddr  = walk_q;
		mem_we = 1'b0;
		waddr  = walk_q;
		wdata  = '0;
		if (accept && ok) begin
			mem_re = 1'b1;
			raddr  = AW'(item.label);
		end
		case (state_q)
			S_CLR: mem_we = 1'b1;
			S_UCLS: begin
				mem_re = 1'b1;
				raddr  = val_addr(val_q);
				mem_we = 1'b1;
				waddr  = AW'(lab_q);
				wdata  = rdata_q + CNT_W'(1);
			end
			S_UVAL: begin
				mem_re = 1'b1;
				raddr  = pair_addr(val_q, lab_q);
				mem_we = 1'b1;
				waddr  = val_addr(val_q);
				wdata  = rdata_q + CNT_W'(1);
			end
			S_UPAIR: begin
				mem_we = 1'b1;
				waddr  = pair_addr(val_q, lab_q);
				wdata  = rdata_q + CNT_W'(1);
			end
			S_WRD: mem_re = 1'b1;
			S_WDAT: mem_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[waddr] <= wdata;
		if (mem_re) rdata_q <= mem_q[raddr];
	end

	assign log_start = (state_q == S_LNGO) || (state_q == S_WDAT);
	assign log_c     = (state_q == S_LNGO) ? n_q : rdata_q;
	assign log_ext   = SW'(log_l);

	ige_clog #(.CNT_W(CNT_W), .LW(LW)) u_clog (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (log_start),
		.c      (log_c),
		.done   (log_done),
		.l      (log_l)
	);

	// clamp a negative numerator to zero
	assign div_start = (state_q == S_DEGO) || (state_q == S_DGGO);
	always_comb begin
		if (state_q == S_DEGO) div_num = acc_e_q[SW-1] ? '0 : acc_e_q[NUM_W-1:0];
		else div_num = acc_g_q[SW-1] ? '0 : acc_g_q[NUM_W-1:0];
	end

	ige_div #(.NUM_W(NUM_W), .DEN_W(CNT_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (n_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			walk_q  <= '0;
			n_q     <= '0;
			drop_q  <= 1'b0;
			last_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q) inside
				S_CLR: begin
					walk_q <= walk_q + 1'b1;
					if (walk_q == AW'(D - 1)) begin
						walk_q  <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE, S_UPAIR: begin
					if (accept) begin
						lab_q  <= item.label;
						val_q  <= item.attr_value;
						last_q <= item.last;
						if (ok) begin
							n_q     <= n_q + 1'b1;
							state_q <= S_UCLS;
						end else begin
							drop_q  <= 1'b1;
							state_q <= item.last ? S_LNGO : S_IDLE;
						end
					end else if (state_q == S_UPAIR) begin
						state_q <= last_q ? S_LNGO : S_IDLE;
					end
				end
				S_UCLS: state_q <= S_UVAL;
				S_UVAL: state_q <= S_UPAIR;
				S_LNGO: state_q <= S_LNW;
				S_LNW: begin
					if (log_done) begin
						acc_e_q <= log_ext;
						acc_g_q <= log_ext;
						walk_q  <= '0;
						state_q <= S_WRD;
					end
				end
				S_WRD: state_q <= S_WDAT;
				S_WDAT: state_q <= S_WLOG;
				S_WLOG: begin
					if (log_done) begin
						if (walk_q < AW'(NUM_CLASSES)) begin
							acc_e_q <= acc_e_q - log_ext;
							acc_g_q <= acc_g_q - log_ext;
						end else if (walk_q < AW'(NUM_CLASSES + NUM_VALUES)) begin
							acc_g_q <= acc_g_q - log_ext;
						end else begin
							acc_g_q <= acc_g_q + log_ext;
						end
						if (walk_q == AW'(D - 1)) begin
							state_q <= S_DEGO;
						end else begin
							walk_q  <= walk_q + 1'b1;
							state_q <= S_WRD;
						end
					end
				end
				S_DEGO: state_q <= S_DEW;
				S_DEW: begin
					if (div_done) begin
						ent_q   <= div_quo;
						state_q <= S_DGGO;
					end
				end
				S_DGGO: state_q <= S_DGW;
				S_DGW: begin
					if (div_done) begin
						result_q.label_entropy <= ent_q;
						result_q.info_gain     <= div_quo;
						result_q.sample_total  <= TOTAL_W'(n_q);
						result_q.overflow      <= drop_q;
						done_q  <= 1'b1;
						n_q     <= '0;
						drop_q  <= 1'b0;
						last_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CNT_W'(MAX_SAMPLES))
		else $error("sample count beyond capacity");

	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (n_q == '0 && !drop_q))
		else $error("set not cleared with result");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !mem_we)
		else $error("counter write while idle");

	a_counted_update: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && ok) |=> (state_q == S_UCLS && mem_we))
		else $error("counted item did not start its update");

endmodule

@@ bench/information_gain_engine_core_tb.sv @@
module information_gain_engine_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ige_pkg::*;

	localparam int N_CLS      = DEF_NUM_CLASSES;
	localparam int N_VAL      = DEF_NUM_VALUES;
	localparam int CAPACITY   = DEF_MAX_SAMPLES;
	localparam int RAND_ITEMS = 930;
	localparam int STALL_MAX  = 300000;

	logic    clk;
	logic    arst_n;
	logic    start;
	item_t   item;
	logic    busy;
	logic    done;
	result_t result;

	information_gain_engine_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// counts of the open set, as the block should hold them
	int unsigned class_tally[N_CLS];
	int unsigned value_tally[N_VAL];
	int unsigned pair_tally[N_VAL*N_CLS];
	int unsigned set_size;
	bit          set_dropped;

	result_t     gain_queue[$];
	int          errors;
	int          stall_cycles;
	bit          calm;

	typedef struct {
		item_t   it;
		bit      typed;
		result_t res;
	} row_t;

	// round(c * log2(c)) in Q.16, log2 by repeated squaring to 40 fraction bits
	function automatic longint xlogx(int unsigned c);
		int unsigned      k;
		logic [63:0]      m;
		logic [63:0]      frac;
		logic [63:0]      logq;
		logic [63:0]      v;
		logic [127:0]     sq;
		k = 0;
		frac = '0;
		if (c < 2)
			return 0;
		while (k < 31 && (c >> (k + 1)) != 0)
			k++;
		m = 64'(c) << (63 - k);
		for (int i = 0; i < FRAC_BITS; i++) begin
			sq = 128'(m) * 128'(m);
			if (sq[127]) begin
				m = sq[127:64];
				frac = {frac[62:0], 1'b1};
			end else begin
				m = sq[126:63];
				frac = {frac[62:0], 1'b0};
			end
		end
		logq = (64'(k) << FRAC_BITS) | frac;
		v = 64'(c) * logq;
		return longint'((v + (64'd1 << 23)) >> 24);
	endfunction

	function automatic logic [OUT_W-1:0] bits_per_sample(longint num, int unsigned n);
		longint q;
		if (num <= 0 || n == 0)
			return '0;
		q = num / longint'(n);
		return (q > longint'(OUT_MAX)) ? OUT_MAX : q[OUT_W-1:0];
	endfunction

	function automatic void clear_set();
		foreach (class_tally[i]) class_tally[i] = 0;
		foreach (value_tally[i]) value_tally[i] = 0;
		foreach (pair_tally[i])  pair_tally[i]  = 0;
		set_size = 0;
		set_dropped = 0;
	endfunction

	// count one item; on a closing item return the entropy and gain of the set
	function automatic bit count_sample(item_t it, output result_t res);
		longint h_lab, s_val, s_pair;
		h_lab = 0;
		s_val = 0;
		s_pair = 0;
		if (it.label >= N_CLS || it.attr_value >= N_VAL || set_size >= CAPACITY) begin
			set_dropped = 1;
		end else begin
			class_tally[it.label]++;
			value_tally[it.attr_value]++;
			pair_tally[it.attr_value*N_CLS + it.label]++;
			set_size++;
		end
		if (!it.last)
			return 0;
		h_lab = xlogx(set_size);
		foreach (class_tally[i]) h_lab -= xlogx(class_tally[i]);
		foreach (value_tally[i]) s_val += xlogx(value_tally[i]);
		foreach (pair_tally[i])  s_pair += xlogx(pair_tally[i]);
		res.label_entropy = bits_per_sample(h_lab, set_size);
		res.info_gain     = bits_per_sample(h_lab - s_val + s_pair, set_size);
		res.sample_total  = set_size[TOTAL_W-1:0];
		res.overflow      = set_dropped;
		clear_set();
		return 1;
	endfunction

	task automatic send(item_t it, bit typed = 0, result_t typed_res = '0);
		result_t res;
		if (!calm && $urandom_range(99) < 21) begin
			repeat ($urandom_range(1, 4)) begin
				@(negedge clk);
				start <= 1'b0;
			end
		end
		@(negedge clk);
		start <= 1'b1;
		item  <= it;
		do @(posedge clk); while (busy);
		if (count_sample(it, res)) begin
			if (typed && res !== typed_res)
				$display("%0t predictor disagrees with table: %p vs %p", $time, res,
					typed_res);
			gain_queue.push_back(typed ? typed_res : res);
		end
	endtask

	function automatic item_t mk(int lab, int val, bit fin);
		item_t it;
		it.label      = lab[LABEL_W-1:0];
		it.attr_value = val[VALUE_W-1:0];
		it.last       = fin;
		return it;
	endfunction

	function automatic result_t rs(int h, int g, int n, bit ovf);
		result_t r;
		r.label_entropy = h[OUT_W-1:0];
		r.info_gain     = g[OUT_W-1:0];
		r.sample_total  = n[TOTAL_W-1:0];
		r.overflow      = ovf;
		return r;
	endfunction

	// check results as they leave the block
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (gain_queue.size() == 0) begin
				$display("%0t unexpected result: expected none, actual %p", $time, result);
				errors++;
			end else begin
				want = gain_queue.pop_front();
				if (result.label_entropy !== want.label_entropy) begin
					$display("%0t label_entropy: expected %0d, actual %0d", $time,
						want.label_entropy, result.label_entropy);
					errors++;
				end
				if (result.info_gain !== want.info_gain) begin
					$display("%0t info_gain: expected %0d, actual %0d", $time,
						want.info_gain, result.info_gain);
					errors++;
				end
				if (result.sample_total !== want.sample_total) begin
					$display("%0t sample_total: expected %0d, actual %0d", $time,
						want.sample_total, result.sample_total);
					errors++;
				end
				if (result.overflow !== want.overflow) begin
					$display("%0t overflow: expected %0b, actual %0b", $time,
						want.overflow, result.overflow);
					errors++;
				end
			end
		end
	end

	// end the run if nothing moves for too long
	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_MAX) begin
			$display("FAIL information_gain_engine_core");
			$finish;
		end
	end

	initial begin
		row_t  table_rows[$];
		int    sent;
		int    len;
		int    span;
		int    lab_base;
		int    val_base;
		item_t it;

		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		errors = 0;
		stall_cycles = 0;
		calm = 0;
		clear_set();

		// single sample, two labels, split by value, four-way split
		table_rows.push_back('{mk(0, 0, 1), 1, rs(0, 0, 1, 0)});
		table_rows.push_back('{mk(0, 0, 0), 0, '0});
		table_rows.push_back('{mk(15, 0, 1), 1, rs(65536, 0, 2, 0)});
		table_rows.push_back('{mk(0, 0, 0), 0, '0});
		table_rows.push_back('{mk(15, 15, 1), 1, rs(65536, 65536, 2, 0)});
		table_rows.push_back('{mk(15, 15, 0), 0, '0});
		table_rows.push_back('{mk(15, 0, 0), 0, '0});
		table_rows.push_back('{mk(0, 15, 0), 0, '0});
		table_rows.push_back('{mk(0, 0, 1), 0, '0});
		table_rows.push_back('{mk(1, 8, 0), 0, '0});
		table_rows.push_back('{mk(2, 4, 0), 0, '0});
		table_rows.push_back('{mk(4, 2, 0), 0, '0});
		table_rows.push_back('{mk(8, 1, 1), 1, rs(131072, 131072, 4, 0)});
		table_rows.push_back('{mk(5, 10, 0), 0, '0});
		table_rows.push_back('{mk(10, 5, 0), 0, '0});
		table_rows.push_back('{mk(5, 5, 0), 0, '0});
		table_rows.push_back('{mk(5, 10, 1), 0, '0});

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (table_rows[i])
			send(table_rows[i].it, table_rows[i].typed, table_rows[i].res);

		// random sets, mostly short, some with narrow label and value pools
		sent = 0;
		while (sent < RAND_ITEMS) begin
			calm = (sent > 400 && sent < 600);
			len = ($urandom_range(9) == 0) ? $urandom_range(60, 300) : $urandom_range(1, 30);
			span = $urandom_range(1, 15);
			lab_base = $urandom_range(0, 15 - span);
			val_base = $urandom_range(0, 15 - span);
			for (int j = 0; j < len; j++) begin
				it = mk(lab_base + $urandom_range(span), val_base + $urandom_range(span),
					j == len - 1);
				send(it);
				sent++;
			end
		end
		calm = 0;

		@(negedge clk);
		start <= 1'b0;
		wait (gain_queue.size() == 0);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("PASS information_gain_engine_core");
		else
			$display("FAIL information_gain_engine_core");
		$finish;
	end

endmodule
